>>> rtl/tds_pkg.sv
// ----------------------------------------------------------------------------
// tds_pkg
// Shared types and constants for the step-timer divider search block.
// ----------------------------------------------------------------------------
package tds_pkg;

    localparam int FREQ_W  = 26;
    localparam int CLK_W   = 27;
    localparam int THR_W   = 16;
    localparam int CNT_W   = 16;
    localparam int PAIR_W  = 16;
    localparam int CS_W    = CLK_W + 1;
    localparam int ROOT_W  = 14;
    localparam int STEP_W  = $clog2(CLK_W);

    localparam int PERIOD_LIMIT = 65536;

    localparam logic [CLK_W-1:0]  CLOCK_HZ_RESET   = CLK_W'(84000000);
    localparam logic [THR_W-1:0]  THRESHOLD_RESET  = THR_W'(1000);
    localparam logic [PAIR_W-1:0] PERIOD_RESET     = PAIR_W'(65535);
    localparam logic [PAIR_W-1:0] PRESCALE_RESET   = PAIR_W'(0);

    typedef enum logic [0:0] {
        CFG_CLOCK_HZ  = 1'b0,
        CFG_THRESHOLD = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic signed [FREQ_W-1:0] freq;
        logic                     sine_mode;
        logic [CNT_W-1:0]         counter_now;
        logic [CNT_W-1:0]         compare_three;
    } cmd_t;

    typedef struct packed {
        logic [PAIR_W-1:0] period;
        logic [PAIR_W-1:0] prescale;
        logic              direction;
        logic              reload;
        logic              running;
        logic              no_divider;
    } res_t;

    typedef struct packed {
        logic              found;
        logic [PAIR_W-1:0] period;
        logic [PAIR_W-1:0] prescale;
    } search_res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_A,
        ST_SQRT,
        ST_TRIAL,
        ST_DIV_T,
        ST_EVAL,
        ST_DONE
    } search_state_t;

endpackage

>>> rtl/tds_cmpsub.sv
// ----------------------------------------------------------------------------
// tds_cmpsub
// Shared compare and subtract unit used by the division and root steps.
// ----------------------------------------------------------------------------
module tds_cmpsub
    import tds_pkg::*;
(
    input  logic [CS_W-1:0] x,
    input  logic [CS_W-1:0] y,
    output logic            ge,
    output logic [CS_W-1:0] diff
);

    logic [CS_W:0] wide_diff;

    assign wide_diff = {1'b0, x} - {1'b0, y};
    assign ge        = ~wide_diff[CS_W];
    assign diff      = wide_diff[CS_W-1:0];

endmodule

>>> rtl/tds_search.sv
// ----------------------------------------------------------------------------
// tds_search
// Sequencer that forms clock / |f|, its integer square root and then scans
// the divisors one restoring division at a time on the shared unit.
// ----------------------------------------------------------------------------
module tds_search
    import tds_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [FREQ_W-1:0] mag,
    input  logic [CLK_W-1:0]  clock_hz,
    output logic              idle,
    output logic              done,
    input  logic              take,
    output search_res_t       result
);

    search_state_t      state_reg, state_next;
    logic [CLK_W-1:0]   a_reg, a_next;
    logic [CS_W-1:0]    x_reg, x_next;
    logic [CLK_W-1:0]   q_reg, q_next;
    logic [FREQ_W-1:0]  d_reg, d_next;
    logic [CS_W-1:0]    root_reg, root_next;
    logic [CS_W-1:0]    bit_reg, bit_next;
    logic [ROOT_W-1:0]  lim_reg, lim_next;
    logic [ROOT_W-1:0]  i_reg, i_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               found_reg, found_next;
    logic [ROOT_W-1:0]  best_rem_reg, best_rem_next;
    logic [ROOT_W-1:0]  best_r_reg, best_r_next;
    logic [PAIR_W-1:0]  best_q_reg, best_q_next;

    logic [CS_W-1:0]    cs_x;
    logic [CS_W-1:0]    cs_y;
    logic               cs_ge;
    logic [CS_W-1:0]    cs_diff;
    logic [CS_W-1:0]    x_sh;
    logic [CLK_W-1:0]   q_sh;
    logic [CS_W-1:0]    root_new;
    logic               pick;

    tds_cmpsub u_cmpsub (
        .x    (cs_x),
        .y    (cs_y),
        .ge   (cs_ge),
        .diff (cs_diff)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg        <= a_next;
        x_reg        <= x_next;
        q_reg        <= q_next;
        d_reg        <= d_next;
        root_reg     <= root_next;
        bit_reg      <= bit_next;
        lim_reg      <= lim_next;
        i_reg        <= i_next;
        step_reg     <= step_next;
        best_rem_reg <= best_rem_next;
        best_r_reg   <= best_r_next;
        best_q_reg   <= best_q_next;
    end

    assign x_sh = {x_reg[CS_W-2:0], q_reg[CLK_W-1]};
    assign q_sh = {q_reg[CLK_W-2:0], cs_ge};
    assign root_new = cs_ge ? ((root_reg >> 1) + bit_reg) : (root_reg >> 1);
    assign pick = (!found_reg || (x_reg[ROOT_W-1:0] < best_rem_reg))
                  && (q_reg < CLK_W'(PERIOD_LIMIT));

    always_comb
    begin
        state_next    = state_reg;
        a_next        = a_reg;
        x_next        = x_reg;
        q_next        = q_reg;
        d_next        = d_reg;
        root_next     = root_reg;
        bit_next      = bit_reg;
        lim_next      = lim_reg;
        i_next        = i_reg;
        step_next     = step_reg;
        found_next    = found_reg;
        best_rem_next = best_rem_reg;
        best_r_next   = best_r_reg;
        best_q_next   = best_q_reg;
        cs_x          = x_reg;
        cs_y          = {{(CS_W-FREQ_W){1'b0}}, d_reg};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    q_next     = clock_hz;
                    x_next     = '0;
                    d_next     = mag;
                    step_next  = '0;
                    found_next = 1'b0;
                    state_next = (mag == '0) ? ST_DONE : ST_DIV_A;
                end
            end
            ST_DIV_A, ST_DIV_T:
            begin
                cs_x      = x_sh;
                x_next    = cs_ge ? cs_diff : x_sh;
                q_next    = q_sh;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(CLK_W - 1))
                begin
                    if (state_reg == ST_DIV_A)
                    begin
                        a_next     = q_sh;
                        x_next     = {1'b0, q_sh};
                        root_next  = '0;
                        bit_next   = CS_W'(1) << (2 * ((CLK_W - 1) / 2));
                        state_next = ST_SQRT;
                    end
                    else
                    begin
                        state_next = ST_EVAL;
                    end
                end
            end
            ST_SQRT:
            begin
                cs_y      = root_reg + bit_reg;
                x_next    = cs_ge ? cs_diff : x_reg;
                root_next = root_new;
                bit_next  = bit_reg >> 2;
                if (bit_reg[0])
                begin
                    lim_next   = root_new[ROOT_W-1:0];
                    i_next     = ROOT_W'(2);
                    state_next = ST_TRIAL;
                end
            end
            ST_TRIAL:
            begin
                if (i_reg > lim_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    q_next     = a_reg;
                    x_next     = '0;
                    d_next     = FREQ_W'(i_reg);
                    step_next  = '0;
                    state_next = ST_DIV_T;
                end
            end
            ST_EVAL:
            begin
                i_next     = i_reg + 1'b1;
                state_next = ST_TRIAL;
                if (pick)
                begin
                    found_next    = 1'b1;
                    best_rem_next = x_reg[ROOT_W-1:0];
                    best_r_next   = i_reg;
                    best_q_next   = q_reg[PAIR_W-1:0];
                    if (x_reg[ROOT_W-1:0] == '0)
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (take)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    assign idle            = (state_reg == ST_IDLE);
    assign done            = (state_reg == ST_DONE);
    assign result.found    = found_reg;
    assign result.period   = best_q_reg - 1'b1;
    assign result.prescale = PAIR_W'(best_r_reg) - 1'b1;

    // Trial divisors never fall below two.
    a_trial_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV_T) |-> (d_reg >= FREQ_W'(2)))
        else $error("trial divisor below two");

    // A finished division leaves a remainder below its divisor.
    a_remainder: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EVAL) |-> (x_reg < {{(CS_W-FREQ_W){1'b0}}, d_reg}))
        else $error("remainder not below divisor");

    // A kept divisor lies within the scanned range.
    a_best_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && found_reg)
        |-> (best_r_reg >= ROOT_W'(2) && best_r_reg <= lim_reg))
        else $error("kept divisor outside scan range");

    // A search only leaves the done state when the result is taken.
    a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && !take) |=> (state_reg == ST_DONE))
        else $error("result dropped before it was taken");

endmodule

>>> rtl/timer_divider_search.sv
// ----------------------------------------------------------------------------
// timer_divider_search
// Turns a signed step frequency command into a period and prescaler pair,
// with direction, run and reload flags, for a 16-bit step timer.
//
//   Channel   Handshake              Payload
//   cmd       cmd_valid/cmd_ready    cmd_data (cmd_t)
//   res       res_valid/res_ready    res_data (res_t)
//   cfg       cfg_valid/cfg_ready    cfg_index, cfg_data
//
// A zero command goes straight to the done state. Otherwise one restoring
// division of 27 steps forms clock / |f|, 14 root steps follow, and each
// divisor trial runs a further restoring division on the shared compare
// and subtract unit.
// The command side is not ready while a search runs. A finished result
// waits in the search unit while the output register is still full.
// Reset restores the register defaults and the held timer state.
// ----------------------------------------------------------------------------
module timer_divider_search
    import tds_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  cmd_t              cmd_data,
    output logic              res_valid,
    input  logic              res_ready,
    output res_t              res_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  cfg_index_t        cfg_index,
    input  logic [CLK_W-1:0]  cfg_data
);

    logic [CLK_W-1:0]   clock_hz_reg;
    logic [THR_W-1:0]   threshold_reg;
    logic [PAIR_W-1:0]  held_period_reg;
    logic [PAIR_W-1:0]  held_prescale_reg;
    logic               held_direction_reg;
    logic               run_flag_reg;
    logic               res_valid_reg;
    res_t               res_data_reg;
    res_t               res_data_next;

    logic [FREQ_W-1:0]  mag_reg;
    logic               neg_reg;
    logic               sine_reg;
    logic [CNT_W-1:0]   counter_reg;
    logic [CNT_W-1:0]   compare_reg;

    logic [FREQ_W-1:0]  cmd_mag;
    logic               cmd_fire;
    logic               srch_idle;
    logic               srch_done;
    logic               srch_take;
    search_res_t        srch_res;
    logic               apply;
    logic               differ;

    assign cmd_mag   = cmd_data.freq[FREQ_W-1] ? (FREQ_W'(0) - cmd_data.freq)
                                               : cmd_data.freq;
    assign cmd_ready = srch_idle;
    assign cmd_fire  = cmd_valid && cmd_ready;
    assign cfg_ready = 1'b1;
    assign srch_take = srch_done && (!res_valid_reg || res_ready);

    tds_search u_search (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd_fire),
        .mag      (cmd_mag),
        .clock_hz (clock_hz_reg),
        .idle     (srch_idle),
        .done     (srch_done),
        .take     (srch_take),
        .result   (srch_res)
    );

    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            mag_reg     <= cmd_mag;
            neg_reg     <= cmd_data.freq[FREQ_W-1];
            sine_reg    <= cmd_data.sine_mode;
            counter_reg <= cmd_data.counter_now;
            compare_reg <= cmd_data.compare_three;
        end
    end

    assign apply  = (mag_reg > FREQ_W'(threshold_reg))
                    || (sine_reg && (counter_reg > compare_reg));
    assign differ = (srch_res.period != held_period_reg)
                    || (srch_res.prescale != held_prescale_reg);

    always_comb
    begin
        res_data_next.period     = held_period_reg;
        res_data_next.prescale   = held_prescale_reg;
        res_data_next.direction  = held_direction_reg;
        res_data_next.reload     = 1'b0;
        res_data_next.running    = run_flag_reg;
        res_data_next.no_divider = 1'b0;
        if (mag_reg == '0)
        begin
            res_data_next.running = 1'b0;
        end
        else if (!srch_res.found)
        begin
            res_data_next.no_divider = 1'b1;
        end
        else
        begin
            res_data_next.running = 1'b1;
            if (apply)
            begin
                res_data_next.direction = ~neg_reg;
                if (differ)
                begin
                    res_data_next.period   = srch_res.period;
                    res_data_next.prescale = srch_res.prescale;
                    res_data_next.reload   = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_hz_reg       <= CLOCK_HZ_RESET;
            threshold_reg      <= THRESHOLD_RESET;
            held_period_reg    <= PERIOD_RESET;
            held_prescale_reg  <= PRESCALE_RESET;
            held_direction_reg <= 1'b0;
            run_flag_reg       <= 1'b0;
            res_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_CLOCK_HZ:  clock_hz_reg  <= cfg_data;
                    CFG_THRESHOLD: threshold_reg <= cfg_data[THR_W-1:0];
                endcase
            end
            if (srch_take)
            begin
                held_period_reg    <= res_data_next.period;
                held_prescale_reg  <= res_data_next.prescale;
                held_direction_reg <= res_data_next.direction;
                run_flag_reg       <= res_data_next.running;
                res_valid_reg      <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (srch_take)
        begin
            res_data_reg <= res_data_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking test of timer_divider_search. Commands are sent over the
// valid/ready command channel and every result transfer is checked field by
// field against an in-bench predictor of the divisor search, the apply rule
// and the held timer state. The register settings are changed between
// phases while the block is idle. Both handshake sides idle at random.
// ----------------------------------------------------------------------------
module testbench;

    import tds_pkg::*;

    logic             clk;
    logic             rst_n;
    logic             cmd_valid;
    logic             cmd_ready;
    cmd_t             cmd_data;
    logic             res_valid;
    logic             res_ready;
    res_t             res_data;
    logic             cfg_valid;
    logic             cfg_ready;
    cfg_index_t       cfg_index;
    logic [CLK_W-1:0] cfg_data;

    logic [CLK_W-1:0]  model_clock_hz;
    logic [THR_W-1:0]  model_threshold;
    logic [PAIR_W-1:0] model_period;
    logic [PAIR_W-1:0] model_prescale;
    logic              model_direction;
    logic              model_running;

    res_t pending_results[$];
    int   mismatch_count;
    bit   tx_eager;
    bit   rx_eager;
    int   rx_hold;

    timer_divider_search u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_data  (cmd_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    function automatic res_t predict_timer_pair(input cmd_t c);
        res_t              r;
        logic [FREQ_W-1:0] raw;
        longint unsigned   mag;
        longint unsigned   quotient;
        longint unsigned   root;
        longint unsigned   trial;
        longint unsigned   rem_best;
        longint unsigned   div_best;
        longint unsigned   new_period;
        longint unsigned   new_prescale;
        int                b;
        logic              found;
        raw = c.freq;
        mag = raw[FREQ_W-1] ? (64'd1 << FREQ_W) - raw : raw;
        r.reload = 1'b0;
        r.no_divider = 1'b0;
        if (mag == 0)
        begin
            model_running = 1'b0;
        end
        else
        begin
            quotient = (model_clock_hz == 0) ? 0 : model_clock_hz / mag;
            root = 0;
            for (b = ROOT_W - 1; b >= 0; b--)
            begin
                if ((root | (64'd1 << b)) * (root | (64'd1 << b)) <= quotient)
                    root = root | (64'd1 << b);
            end
            found = 1'b0;
            rem_best = 0;
            div_best = 0;
            for (trial = 2; trial <= root; trial++)
            begin
                if ((!found || quotient % trial < rem_best) && quotient / trial < PERIOD_LIMIT)
                begin
                    found = 1'b1;
                    rem_best = quotient % trial;
                    div_best = trial;
                    if (rem_best == 0)
                        break;
                end
            end
            if (!found)
            begin
                r.no_divider = 1'b1;
            end
            else
            begin
                new_period = quotient / div_best - 1;
                new_prescale = div_best - 1;
                if (mag > model_threshold
                    || (c.sine_mode && c.counter_now > c.compare_three))
                begin
                    model_direction = !raw[FREQ_W-1];
                    if (PAIR_W'(new_period) != model_period
                        || PAIR_W'(new_prescale) != model_prescale)
                    begin
                        model_period = PAIR_W'(new_period);
                        model_prescale = PAIR_W'(new_prescale);
                        r.reload = 1'b1;
                    end
                end
                model_running = 1'b1;
            end
        end
        r.period = model_period;
        r.prescale = model_prescale;
        r.direction = model_direction;
        r.running = model_running;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] expv,
                               input logic [31:0] actv);
        if (expv !== actv)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, expv, actv);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && res_valid && res_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transfer with no expected result waiting");
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("period", 32'(want.period), 32'(res_data.period));
                check_field("prescale", 32'(want.prescale), 32'(res_data.prescale));
                check_field("direction", 32'(want.direction), 32'(res_data.direction));
                check_field("reload", 32'(want.reload), 32'(res_data.reload));
                check_field("running", 32'(want.running), 32'(res_data.running));
                check_field("no_divider", 32'(want.no_divider),
                            32'(res_data.no_divider));
            end
        end
    end

    always @(negedge clk)
    begin
        int pick;
        if (rx_eager)
        begin
            res_ready <= 1'b1;
        end
        else if (rx_hold > 0)
        begin
            rx_hold--;
            res_ready <= 1'b0;
        end
        else
        begin
            pick = $urandom_range(0, 19);
            if (pick < 13)
            begin
                res_ready <= 1'b1;
            end
            else
            begin
                res_ready <= 1'b0;
                rx_hold = (pick < 18) ? $urandom_range(0, 3) : $urandom_range(20, 400);
            end
        end
    end

    // Called just after a rising edge; returns at the edge of the transfer.
    task automatic send_command(input logic signed [FREQ_W-1:0] f, input logic sine,
                                input logic [CNT_W-1:0] cnt,
                                input logic [CNT_W-1:0] cmp3);
        cmd_t c;
        int   gap;
        int   pick;
        c.freq = f;
        c.sine_mode = sine;
        c.counter_now = cnt;
        c.compare_three = cmp3;
        pick = $urandom_range(0, 19);
        if (tx_eager || pick < 12)
            gap = 0;
        else if (pick < 18)
            gap = $urandom_range(1, 4);
        else
            gap = $urandom_range(20, 300);
        @(negedge clk);
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_data <= c;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
        pending_results.push_back(predict_timer_pair(c));
    endtask

    task automatic drain_results();
        @(negedge clk);
        cmd_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_settings(input logic [CLK_W-1:0] clock_hz,
                                  input logic [CLK_W-1:0] threshold_word);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_CLOCK_HZ;
        cfg_data <= clock_hz;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        model_clock_hz = clock_hz;
        @(negedge clk);
        cfg_index <= CFG_THRESHOLD;
        cfg_data <= threshold_word;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        model_threshold = threshold_word[THR_W-1:0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_apply_rules();
        send_command(0, 1'b0, 16'd0, 16'd0);
        send_command(84, 1'b0, 16'd0, 16'd0);
        send_command(84, 1'b1, 16'd1, 16'd0);
        send_command(84, 1'b1, 16'hFFFF, 16'd0);
        send_command(-84, 1'b1, 16'hFFFF, 16'hFFFF);
        send_command(-84, 1'b1, 16'hFFFF, 16'd0);
        send_command(2000, 1'b0, 16'hFFFF, 16'd0);
        send_command(-1000, 1'b0, 16'd0, 16'd0);
        send_command(-1001, 1'b0, 16'd0, 16'hFFFF);
        send_command(1, 1'b0, 16'hAAAA, 16'h5555);
        send_command(-1, 1'b1, 16'd0, 16'hFFFF);
        send_command(0, 1'b1, 16'hFFFF, 16'd0);
        drain_results();
    endtask

    task automatic test_no_divider();
        send_command(26'sd21000000, 1'b0, 16'd0, 16'd0);
        send_command(26'sd28000000, 1'b1, 16'hFFFF, 16'd0);
        send_command(26'sd33554431, 1'b0, 16'd0, 16'd0);
        send_command(-26'sd33554431, 1'b1, 16'h5555, 16'hAAAA);
        send_command(26'h2000000, 1'b0, 16'd0, 16'd0);
        drain_results();
    endtask

    task automatic test_register_extremes();
        write_settings(27'd134217727, 27'h7FF0000);
        send_command(1, 1'b0, 16'd0, 16'd0);
        send_command(-3, 1'b0, 16'd0, 16'd0);
        send_command(256, 1'b1, 16'd0, 16'hFFFF);
        drain_results();
        write_settings(27'd1000000, 27'h000FFFF);
        send_command(100, 1'b0, 16'd0, 16'd0);
        send_command(-65535, 1'b0, 16'd0, 16'd0);
        send_command(65536, 1'b0, 16'd0, 16'd0);
        drain_results();
        write_settings(27'd0, 27'd0);
        send_command(1, 1'b0, 16'd0, 16'd0);
        send_command(0, 1'b0, 16'd0, 16'd0);
        drain_results();
    endtask

    task automatic test_random_commands();
        int                       phase;
        int                       item;
        int                       pick;
        int                       mag;
        bit                       neg;
        logic [CLK_W-1:0]         clock_hz;
        logic [THR_W-1:0]         threshold;
        logic [CNT_W-1:0]         cnt;
        logic [CNT_W-1:0]         cmp3;
        logic signed [FREQ_W-1:0] f;
        for (phase = 0; phase < 4; phase++)
        begin
            pick = $urandom_range(0, 3);
            clock_hz = (pick == 0) ? 27'd1000000 :
                       (pick == 1) ? 27'd134217727 :
                       CLK_W'($urandom_range(1000000, 134217727));
            pick = $urandom_range(0, 3);
            threshold = (pick == 0) ? 16'd0 : (pick == 1) ? 16'hFFFF :
                        THR_W'($urandom_range(0, 65535));
            write_settings(clock_hz, {(CLK_W-THR_W)'($urandom), threshold});
            tx_eager = (phase == 2);
            rx_eager = (phase == 2);
            for (item = 0; item < 20; item++)
            begin
                neg = 1'($urandom_range(0, 1));
                pick = $urandom_range(0, 19);
                if (pick == 0)
                    mag = 0;
                else if (pick == 1)
                    mag = neg ? $urandom_range(33554431, 33554432) : 33554431;
                else if (pick < 10)
                    mag = $urandom_range(256, 65535);
                else
                    mag = $urandom_range(65536, 33554431);
                f = neg ? FREQ_W'(-mag) : FREQ_W'(mag);
                cnt = CNT_W'($urandom);
                cmp3 = ($urandom_range(0, 7) == 0) ? cnt : CNT_W'($urandom);
                send_command(f, 1'($urandom_range(0, 1)), cnt, cmp3);
            end
            drain_results();
            tx_eager = 1'b0;
            rx_eager = 1'b0;
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cmd_valid = 1'b0;
        cmd_data = '0;
        res_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_CLOCK_HZ;
        cfg_data = '0;
        mismatch_count = 0;
        tx_eager = 1'b0;
        rx_eager = 1'b0;
        rx_hold = 0;
        model_clock_hz = CLOCK_HZ_RESET;
        model_threshold = THRESHOLD_RESET;
        model_period = PERIOD_RESET;
        model_prescale = PRESCALE_RESET;
        model_direction = 1'b0;
        model_running = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_apply_rules();
        test_no_divider();
        test_register_extremes();
        test_random_commands();
        drain_results();
        repeat (100) @(posedge clk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #400_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

>>> sim.f
rtl/tds_pkg.sv
rtl/tds_cmpsub.sv
rtl/tds_search.sv
rtl/timer_divider_search.sv
tb/testbench.sv
